// ----- rtl/htr_pkg.sv -----
// ----------------------------------------------------------------------------
// htr_pkg
// Shared constants, types and MD5 tables for the hashed twister generator.
// ----------------------------------------------------------------------------
package htr_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int MAX_DRAWS    = 64;
  localparam int WORD_W       = 32;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int DRAW_W       = $clog2(MAX_DRAWS);

  localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908b0df;

  localparam logic [WORD_W-1:0] MD5_IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] MD5_IV_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] MD5_IV_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] MD5_IV_D = 32'h10325476;

  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_RAW   = 2'd2;

  typedef logic [3:0][WORD_W-1:0] quad_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TW_PRE,
    ST_TW_FIRST,
    ST_TW_RD_NEXT,
    ST_TW_RD_FAR,
    ST_TW_WRITE,
    ST_MD_RD,
    ST_MD_RUN,
    ST_MD_WR,
    ST_DRAW_RD,
    ST_DRAW_CHK
  } state_t;

  function automatic logic [WORD_W-1:0] md5_k(input logic [5:0] r);
    logic [WORD_W-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index; the top two round bits pick the formula, taken modulo 16.
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] g;
    i = r[3:0];
    case (r[5:4])
      2'd0: g = i;
      2'd1: g = 4'(4'd5 * i + 4'd1);
      2'd2: g = 4'(4'd3 * i + 4'd5);
      default: g = 4'(4'd7 * i);
    endcase
    return g;
  endfunction

  // A padded 16-byte message: the data, the 0x80 marker and the bit length.
  function automatic logic [WORD_W-1:0] md5_msg(input quad_t m, input logic [3:0] g);
    logic [WORD_W-1:0] w;
    case (g)
      4'd0: w = m[0];
      4'd1: w = m[1];
      4'd2: w = m[2];
      4'd3: w = m[3];
      4'd4: w = 32'h00000080;
      4'd14: w = 32'd128;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/htr_if.sv -----
// ----------------------------------------------------------------------------
// htr_in_if / htr_out_if
// Valid/ready channels for requests and results of the hashed twister.
// ----------------------------------------------------------------------------
interface htr_in_if;
  import htr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [WORD_W-1:0]        seed_word;
  logic signed [WORD_W-1:0] range_start;
  logic signed [WORD_W-1:0] range_end;
  modport source (output valid, mode, seed_word, range_start, range_end, input ready);
  modport sink   (input valid, mode, seed_word, range_start, range_end, output ready);
endinterface

interface htr_out_if;
  import htr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_word;
  modport source (output valid, result_word, input ready);
  modport sink   (input valid, result_word, output ready);
endinterface

// ----- rtl/htr_ram.sv -----
// ----------------------------------------------------------------------------
// htr_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module htr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/htr_md5.sv -----
// ----------------------------------------------------------------------------
// htr_md5
// MD5 digest of one 16-byte message, one round per cycle over its 64 rounds.
// ----------------------------------------------------------------------------
module htr_md5 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  htr_pkg::quad_t msg,
  output logic           done,
  output htr_pkg::quad_t digest
);
  import htr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [5:0]        round_r;
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [WORD_W-1:0] f, sum, b_new;
  logic [2*WORD_W-1:0] rot;

  always_comb begin
    case (round_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum   = f + a_r + md5_k(round_r) + md5_msg(msg, md5_g(round_r));
    rot   = {sum, sum} << md5_s(round_r);
    b_new = b_r + rot[2*WORD_W-1:WORD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (round_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (round_r == 6'd63)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= MD5_IV_A;
      b_r     <= MD5_IV_B;
      c_r     <= MD5_IV_C;
      d_r     <= MD5_IV_D;
      round_r <= '0;
    end else if (busy_r) begin
      a_r     <= d_r;
      d_r     <= c_r;
      c_r     <= b_r;
      b_r     <= b_new;
      round_r <= round_r + 6'd1;
    end
  end

  assign done      = done_r;
  assign digest[0] = a_r + MD5_IV_A;
  assign digest[1] = b_r + MD5_IV_B;
  assign digest[2] = c_r + MD5_IV_C;
  assign digest[3] = d_r + MD5_IV_D;
endmodule

// ----- rtl/hashed_twister_range_random.sv -----
// ----------------------------------------------------------------------------
// hashed_twister_range_random
// Twister generator with an MD5-whitened output pool and ranged draws.
// ----------------------------------------------------------------------------
// A seed transaction writes the next of the 624 state words. A raw or
// ranged request draws its words from the pool; an empty or single-value
// range is answered on accept without a draw. When the pool is empty a
// refill runs first: the twist goes through the state memory word by word
// in its read-next, read-far and write states (its single read port sets
// that pace), then each of the 156 four-word blocks is read, hashed by the
// round-serial MD5 unit in 64 rounds and written back to the pool. The
// block takes no request while it works, nor while an untaken result would
// be overwritten.
module hashed_twister_range_random (
  input logic        clk,
  input logic        rst_n,
  htr_in_if.sink     in_ch,
  htr_out_if.source  out_ch
);
  import htr_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] POOL_END  = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] LAST_BLK  = ADDR_W'(STATE_WORDS - 4);
  localparam logic [ADDR_W-1:0] FAR_WRAP  = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [ADDR_W-1:0] FAR_STEP  = ADDR_W'(TWIST_OFFSET);
  localparam logic [DRAW_W-1:0] LAST_DRAW = DRAW_W'(MAX_DRAWS - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] seed_pos_r, seed_pos_nxt;
  logic [ADDR_W-1:0] read_pos_r, read_pos_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] nxt_r, nxt_nxt;
  quad_t             m_r, m_nxt;
  logic [WORD_W-1:0] start_r, start_nxt;
  logic [WORD_W-1:0] range_r, range_nxt;
  logic [WORD_W-1:0] mask_r, mask_nxt;
  logic              raw_r, raw_nxt;
  logic [DRAW_W-1:0] draws_r, draws_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              accept, pool_empty, empty_rng, single_rng, full_rng, fits, last_draw;
  logic [WORD_W-1:0] diff, smear, n_masked, y;
  logic [ADDR_W-1:0] idx_next, idx_far;

  logic              tw_we, hw_we, md_start, md_done;
  logic [ADDR_W-1:0] tw_waddr, tw_raddr, hw_waddr;
  logic [WORD_W-1:0] tw_wdata, tw_rdata, hw_wdata, hw_rdata;
  quad_t             digest;

  assign accept     = in_ch.valid && in_ch.ready;
  assign pool_empty = (read_pos_r == POOL_END);
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_word = out_word_r;

  // Range set-up from the request fields.
  always_comb begin
    diff  = WORD_W'(in_ch.range_end) - WORD_W'(in_ch.range_start);
    smear = diff;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    empty_rng  = in_ch.range_end < in_ch.range_start;
    single_rng = in_ch.range_end == in_ch.range_start;
    full_rng   = (diff + 32'd1) == '0;
  end

  assign n_masked  = hw_rdata & mask_r;
  assign fits      = n_masked < range_r;
  assign last_draw = (draws_r == LAST_DRAW);
  assign idx_next  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign idx_far   = (idx_r >= FAR_WRAP) ? idx_r - FAR_WRAP : idx_r + FAR_STEP;
  assign y         = {cur_r[WORD_W-1], nxt_r[WORD_W-2:0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && ((in_ch.mode == MODE_RAW) ||
            ((in_ch.mode == MODE_RANGE) && !empty_rng && !single_rng))) begin
          state_nxt = pool_empty ? ST_TW_PRE : ST_DRAW_RD;
        end
      end
      ST_TW_PRE:     state_nxt = ST_TW_FIRST;
      ST_TW_FIRST:   state_nxt = ST_TW_RD_NEXT;
      ST_TW_RD_NEXT: state_nxt = ST_TW_RD_FAR;
      ST_TW_RD_FAR:  state_nxt = ST_TW_WRITE;
      ST_TW_WRITE:   state_nxt = (idx_r == LAST_IDX) ? ST_MD_RD : ST_TW_RD_NEXT;
      ST_MD_RD:      state_nxt = (sub_r == 3'd4) ? ST_MD_RUN : ST_MD_RD;
      ST_MD_RUN:     state_nxt = md_done ? ST_MD_WR : ST_MD_RUN;
      ST_MD_WR: begin
        if (sub_r == 3'd3) begin
          state_nxt = (blk_r == LAST_BLK) ? ST_DRAW_RD : ST_MD_RD;
        end
      end
      ST_DRAW_RD:    state_nxt = ST_DRAW_CHK;
      ST_DRAW_CHK: begin
        if (raw_r || fits || last_draw) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = pool_empty ? ST_TW_PRE : ST_DRAW_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    seed_pos_nxt  = seed_pos_r;
    read_pos_nxt  = read_pos_r;
    idx_nxt       = idx_r;
    blk_nxt       = blk_r;
    sub_nxt       = sub_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    m_nxt         = m_r;
    start_nxt     = start_r;
    range_nxt     = range_r;
    mask_nxt      = mask_r;
    raw_nxt       = raw_r;
    draws_nxt     = draws_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    tw_we    = 1'b0;
    tw_waddr = seed_pos_r;
    tw_wdata = in_ch.seed_word;
    tw_raddr = '0;
    hw_we    = 1'b0;
    hw_waddr = blk_r + ADDR_W'(sub_r[1:0]);
    hw_wdata = digest[sub_r[1:0]];
    md_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idx_nxt   = '0;
        draws_nxt = '0;
        start_nxt = WORD_W'(in_ch.range_start);
        range_nxt = diff + 32'd1;
        mask_nxt  = smear;
        raw_nxt   = (in_ch.mode == MODE_RAW) || full_rng;
        if (accept) begin
          case (in_ch.mode)
            MODE_SEED: begin
              tw_we        = 1'b1;
              seed_pos_nxt = (seed_pos_r == LAST_IDX) ? '0 : seed_pos_r + 1'b1;
              read_pos_nxt = POOL_END;
            end
            MODE_RANGE: begin
              if (empty_rng) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = WORD_W'(in_ch.range_start) - 32'd1;
              end else if (single_rng) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = WORD_W'(in_ch.range_start);
              end
            end
            default: ;
          endcase
        end
      end
      ST_TW_PRE: tw_raddr = '0;
      ST_TW_FIRST: cur_nxt = tw_rdata;
      ST_TW_RD_NEXT: tw_raddr = idx_next;
      ST_TW_RD_FAR: begin
        tw_raddr = idx_far;
        nxt_nxt  = tw_rdata;
      end
      ST_TW_WRITE: begin
        tw_we    = 1'b1;
        tw_waddr = idx_r;
        tw_wdata = tw_rdata ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
        cur_nxt  = nxt_r;
        idx_nxt  = idx_next;
        blk_nxt  = '0;
        sub_nxt  = '0;
      end
      ST_MD_RD: begin
        tw_raddr = blk_r + ADDR_W'(sub_r[1:0]);
        if (sub_r != 3'd0) begin
          m_nxt[2'(sub_r - 3'd1)] = tw_rdata;
        end
        if (sub_r == 3'd4) begin
          md_start = 1'b1;
          sub_nxt  = '0;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_MD_WR: begin
        hw_we = 1'b1;
        if (sub_r == 3'd3) begin
          sub_nxt = '0;
          if (blk_r == LAST_BLK) begin
            read_pos_nxt = '0;
          end else begin
            blk_nxt = blk_r + ADDR_W'(4);
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_DRAW_RD: read_pos_nxt = read_pos_r + 1'b1;
      ST_DRAW_CHK: begin
        if (raw_r) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hw_rdata;
        end else if (fits) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = n_masked + start_r;
        end else if (last_draw) begin
          // Draw limit reached: fold the last rejected draw back into range.
          out_valid_nxt = 1'b1;
          out_word_nxt  = start_r + n_masked - range_r;
        end else begin
          draws_nxt = draws_r + 1'b1;
          idx_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_pos_r  <= '0;
      read_pos_r  <= POOL_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_pos_r  <= seed_pos_nxt;
      read_pos_r  <= read_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    blk_r      <= blk_nxt;
    sub_r      <= sub_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    m_r        <= m_nxt;
    start_r    <= start_nxt;
    range_r    <= range_nxt;
    mask_r     <= mask_nxt;
    raw_r      <= raw_nxt;
    draws_r    <= draws_nxt;
    out_word_r <= out_word_nxt;
  end

  htr_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_twist_ram (
    .clk   (clk),
    .we    (tw_we),
    .waddr (tw_waddr),
    .wdata (tw_wdata),
    .raddr (tw_raddr),
    .rdata (tw_rdata)
  );

  htr_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_pool_ram (
    .clk   (clk),
    .we    (hw_we),
    .waddr (hw_waddr),
    .wdata (hw_wdata),
    .raddr (read_pos_r),
    .rdata (hw_rdata)
  );

  htr_md5 u_md5 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .msg    (m_r),
    .done   (md_done),
    .digest (digest)
  );
endmodule

// ----- rtl/htr_chk.sv -----
// ----------------------------------------------------------------------------
// htr_chk
// Port-level checks for the hashed twister generator, bound to the top level.
// ----------------------------------------------------------------------------
module htr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_word
);
  import htr_pkg::*;

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_word))
    else $error("stalled result changed");

  // A pending result that is not taken blocks new requests.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result would be overwritten");

  // A seed load completes at once and yields no result.
  a_seed_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_SEED) |=> in_ready && !out_valid)
    else $error("seed load did not complete in one cycle");
endmodule

bind hashed_twister_range_random htr_chk u_htr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_mode         (in_ch.mode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_word (out_ch.result_word)
);
